/* design/jse_pkg.sv */
// Package for the JSON string escaper: payload types, character codes and
// the hex digit helper. No dependencies.
`timescale 1ns / 1ps

package jse_pkg;

  localparam int unsigned CpW     = 21;
  localparam int unsigned MaxRun  = 6;
  localparam int unsigned IdxW    = 3;

  typedef logic [CpW-1:0] cp_t;
  typedef logic [IdxW-1:0] idx_t;

  // Action codes of an input beat
  typedef enum logic [1:0] {
    ActOpen  = 2'd0,
    ActChar  = 2'd1,
    ActClose = 2'd2,
    ActNone  = 2'd3
  } action_e;

  localparam cp_t ChQuote     = CpW'('h22);
  localparam cp_t ChBackslash = CpW'('h5C);
  localparam cp_t ChSlash     = CpW'('h2F);
  localparam cp_t ChBs        = CpW'('h08);
  localparam cp_t ChTab       = CpW'('h09);
  localparam cp_t ChLf        = CpW'('h0A);
  localparam cp_t ChFf        = CpW'('h0C);
  localparam cp_t ChCr        = CpW'('h0D);
  localparam cp_t ChLowB      = CpW'('h62);
  localparam cp_t ChLowT      = CpW'('h74);
  localparam cp_t ChLowN      = CpW'('h6E);
  localparam cp_t ChLowF      = CpW'('h66);
  localparam cp_t ChLowR      = CpW'('h72);
  localparam cp_t ChLowU      = CpW'('h75);
  localparam cp_t ChZero      = CpW'('h30);
  localparam cp_t ChLowA      = CpW'('h61);

  // Lowercase hex digit for one nibble
  function automatic cp_t hex_digit(input logic [3:0] nib);
    cp_t d;
    if (nib < 4'd10) begin
      d = ChZero + CpW'(nib);
    end else begin
      d = ChLowA + CpW'(nib - 4'd10);
    end
    return d;
  endfunction

endpackage

/* design/jse_in_if.sv */
// Input channel of the JSON string escaper: valid/ready plus one item.
// Depends on jse_pkg.
`timescale 1ns / 1ps

interface jse_in_if import jse_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] action;
  cp_t        code_point;

  modport source (output valid, output action, output code_point, input ready);
  modport sink   (input valid, input action, input code_point, output ready);
endinterface

/* design/jse_out_if.sv */
// Output channel of the JSON string escaper: valid/ready plus one character.
// Depends on jse_pkg.
`timescale 1ns / 1ps

interface jse_out_if import jse_pkg::*; ();
  logic valid;
  logic ready;
  cp_t  out_char;
  logic run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

/* design/json_string_escaper.sv */
// JSON string escaper top level.
// Depends on jse_pkg, jse_in_if and jse_out_if.
`timescale 1ns / 1ps

// Turns a stream of code points into a quoted JSON string literal. Open and
// close beats each give one double quote; a character beat gives its escaped
// form (two characters for short escapes, six for \uXXXX, one otherwise), the
// last character of each run flagged with run_last. Each input beat is
// expanded into a registered run; the output channel drains it one
// character per cycle while out_o.ready is high. A new beat is accepted
// when no run is held or as the last character of the current run is
// taken, so runs follow back to back. A beat with the unused action code
// is taken and gives no output. No reset-time setup is needed.
module json_string_escaper
  import jse_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  jse_in_if.sink    in_i,
  jse_out_if.source out_o
);

  cp_t  run_q [MaxRun];
  cp_t  run_d [MaxRun];
  idx_t len_q, len_d;
  idx_t idx_q;
  logic busy_q;

  logic run_end, take, fire;
  cp_t  c;
  logic is_ctrl;

  assign run_end = (idx_q == len_q - idx_t'(1));
  assign fire    = out_o.valid && out_o.ready;
  assign in_i.ready = !busy_q || (out_o.ready && run_end);
  assign take    = in_i.valid && in_i.ready;

  assign out_o.valid    = busy_q;
  assign out_o.out_char = run_q[idx_q];
  assign out_o.run_last = run_end;

  // Expand the incoming beat into its escaped run
  assign c       = in_i.code_point;
  assign is_ctrl = (c <= CpW'('h1F)) || ((c >= CpW'('h7F)) && (c <= CpW'('h9F)));

  always_comb begin
    for (int k = 0; k < MaxRun; k++) begin
      run_d[k] = '0;
    end
    len_d    = '0;
    run_d[0] = ChBackslash;
    unique case (action_e'(in_i.action))
      ActOpen, ActClose: begin
        run_d[0] = ChQuote;
        len_d    = idx_t'(1);
      end
      ActChar: begin
        len_d = idx_t'(2);
        priority if (c == ChBs) begin
          run_d[1] = ChLowB;
        end else if (c == ChTab) begin
          run_d[1] = ChLowT;
        end else if (c == ChLf) begin
          run_d[1] = ChLowN;
        end else if (c == ChFf) begin
          run_d[1] = ChLowF;
        end else if (c == ChCr) begin
          run_d[1] = ChLowR;
        end else if (c == ChQuote || c == ChBackslash || c == ChSlash) begin
          run_d[1] = c;
        end else if (is_ctrl) begin
          run_d[1] = ChLowU;
          run_d[2] = hex_digit(c[15:12]);
          run_d[3] = hex_digit(c[11:8]);
          run_d[4] = hex_digit(c[7:4]);
          run_d[5] = hex_digit(c[3:0]);
          len_d    = idx_t'(MaxRun);
        end else begin
          run_d[0] = c;
          len_d    = idx_t'(1);
        end
      end
      default: begin
        len_d = '0;
      end
    endcase
  end

  // Run control: load on an accepted beat, step on each output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      len_q  <= '0;
    end else if (take) begin
      busy_q <= (len_d != '0);
      idx_q  <= '0;
      len_q  <= len_d;
    end else if (fire) begin
      if (run_end) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + idx_t'(1);
      end
    end
  end

  // Run characters, payload only
  always_ff @(posedge clk_i) begin
    if (take) begin
      run_q <= run_d;
    end
  end

endmodule
